FILE: rtl/rpn_pkg.sv
// shared types, constants and helpers for the rpn calculator
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int CHAR_W          = 8;
  localparam int VAL_W           = 48;
  localparam int FRAC_W          = 16;
  localparam int STAT_W          = 2;
  localparam int DIGIT_W         = 4;
  localparam int HALF_W          = VAL_W / 2;
  localparam int PROD_W          = 2 * VAL_W;
  localparam int DIV_W           = VAL_W + FRAC_W;
  localparam int MAG_W           = PROD_W - FRAC_W;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_QUIT  = 8'h71;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_DIGIT,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_EQUAL,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } sat_val_t;

  // signed result from magnitude and sign, clamped to the 48-bit range
  function automatic sat_val_t from_mag(input logic [MAG_W-1:0] mag, input logic neg);
    sat_val_t         res;
    logic [VAL_W-1:0] neg_val;
    neg_val = ~mag[VAL_W-1:0] + {{(VAL_W-1){1'b0}}, 1'b1};
    if (neg) begin
      if ((|mag[MAG_W-1:VAL_W]) || (mag[VAL_W-1] && (|mag[VAL_W-2:0]))) begin
        res = '{val: VAL_MIN, sat: 1'b1};
      end else begin
        res = '{val: neg_val, sat: 1'b0};
      end
    end else begin
      if (|mag[MAG_W-1:VAL_W-1]) begin
        res = '{val: VAL_MAX, sat: 1'b1};
      end else begin
        res = '{val: mag[VAL_W-1:0], sat: 1'b0};
      end
    end
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + {{(VAL_W-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

FILE: rtl/rpn_stack_calculator_core.sv
// top level of the reverse polish calculator
// a '=' word is on the result side in the cycle after it is taken, back end idle
// states per word: digit, 'q', '=' idle; + - idle, read; * idle, read, multiply
// (four 24x24 products), finish; '/' idle, read, the 64-step radix-2 divider, finish
// reset: synchronous active-low rst_n clears queue, stack depth, sticky flag, result slot
// stack memory is not cleared; no entry is read before it is written
`timescale 1ns / 1ps
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word channel
  input  logic                              in_push,
  input  logic [rpn_pkg::CHAR_W-1:0]        in_character,
  output logic                              in_full,
  // result word channel
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic signed [rpn_pkg::VAL_W-1:0]  out_value,
  output logic [rpn_pkg::STAT_W-1:0]        out_status,
  output logic                              out_saturated
);

  // front to back command queue
  logic           q_valid;
  rpn_pkg::item_t q_item;
  logic           q_pop;

  // front end: drops characters that mean nothing, queues the rest
  rpn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_character (in_character),
    .in_full      (in_full),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back end: stack, arithmetic and the result register
  rpn_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_saturated (out_saturated)
  );

endmodule

FILE: rtl/rpn_front.sv
// input front end: classifies characters and queues commands for execution
`timescale 1ns / 1ps
module rpn_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic [rpn_pkg::CHAR_W-1:0]  in_character,
  output logic                        in_full,
  output logic                        q_valid,
  output rpn_pkg::item_t              q_item,
  input  logic                        q_pop
);

  localparam int PTR_W = $clog2(rpn_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rpn_pkg::QUEUE_DEPTH + 1);

  rpn_pkg::item_t     queue_r [rpn_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  rpn_pkg::item_t            cls_item;
  logic                      cls_keep;
  logic [rpn_pkg::CHAR_W-1:0] digit_diff;
  logic                      wr_en;
  logic                      rd_en;

  // character classification
  always_comb begin
    digit_diff     = in_character - rpn_pkg::CH_ZERO;
    cls_item.digit = digit_diff[rpn_pkg::DIGIT_W-1:0];
    cls_item.cmd   = rpn_pkg::CMD_DIGIT;
    cls_keep       = 1'b1;
    case (in_character) inside
      [rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]: cls_item.cmd = rpn_pkg::CMD_DIGIT;
      rpn_pkg::CH_PLUS:                    cls_item.cmd = rpn_pkg::CMD_ADD;
      rpn_pkg::CH_MINUS:                   cls_item.cmd = rpn_pkg::CMD_SUB;
      rpn_pkg::CH_STAR:                    cls_item.cmd = rpn_pkg::CMD_MUL;
      rpn_pkg::CH_SLASH:                   cls_item.cmd = rpn_pkg::CMD_DIV;
      rpn_pkg::CH_EQUAL:                   cls_item.cmd = rpn_pkg::CMD_EQUAL;
      rpn_pkg::CH_QUIT:                    cls_item.cmd = rpn_pkg::CMD_CLEAR;
      default:                             cls_keep     = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == CNT_W'(rpn_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = queue_r[rd_ptr_r];

  assign wr_en = in_push && !in_full && cls_keep;
  assign rd_en = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(rpn_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(rpn_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

FILE: rtl/rpn_div.sv
// radix-2 restoring divider for the fixed-point quotient
`timescale 1ns / 1ps
module rpn_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpn_pkg::DIV_W-1:0]  dividend,
  input  logic [rpn_pkg::VAL_W-1:0]  divisor,
  output logic                       done,
  output logic [rpn_pkg::DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(rpn_pkg::DIV_W);

  logic [rpn_pkg::VAL_W-1:0] rem_r, rem_nxt;
  logic [rpn_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [rpn_pkg::VAL_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [rpn_pkg::VAL_W:0]   shifted;
  logic [rpn_pkg::VAL_W:0]   diff;
  logic                      ge;

  always_comb begin
    shifted = {rem_r, quo_r[rpn_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit per cycle
      rem_nxt = ge ? diff[rpn_pkg::VAL_W-1:0] : shifted[rpn_pkg::VAL_W-1:0];
      quo_nxt = {quo_r[rpn_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rpn_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/rpn_exec.sv
// execution back end: operand stack, arithmetic sequencer and result register
`timescale 1ns / 1ps
module rpn_exec #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  rpn_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [rpn_pkg::VAL_W-1:0]  out_value,
  output logic [rpn_pkg::STAT_W-1:0]        out_status,
  output logic                              out_saturated
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int VW = rpn_pkg::VAL_W;
  localparam int HW = rpn_pkg::HALF_W;
  localparam int PW = rpn_pkg::PROD_W;
  localparam int FW = rpn_pkg::FRAC_W;
  localparam int MW = rpn_pkg::MAG_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0]   mem [STACK_DEPTH];
  logic [VW-1:0]   rd_data_r;
  logic            mem_we;
  logic            mem_re;
  logic [DW-1:0]   depth_m1;
  logic [DW-1:0]   depth_m2;

  logic [DW-1:0]   depth_r, depth_nxt;
  logic            sticky_r, sticky_nxt;
  logic [VW-1:0]   top_r, top_nxt;
  rpn_pkg::cmd_t   op_r, op_nxt;
  logic [VW-1:0]   ma_r, ma_nxt;
  logic [VW-1:0]   mb_r, mb_nxt;
  logic            neg_r, neg_nxt;
  logic [2:0]      mcnt_r, mcnt_nxt;
  logic [VW-1:0]   prod_r, prod_nxt;
  logic [1:0]      psh_r, psh_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [MW-1:0]   mag_r, mag_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [VW-1:0]             out_value_r, out_value_nxt;
  logic [rpn_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic                      out_sat_r, out_sat_nxt;

  logic                      out_free;
  logic [VW:0]               sum;
  logic [HW-1:0]             a_half;
  logic [HW-1:0]             b_half;
  logic [PW-1:0]             addend;
  logic [PW-1:0]             acc_sum;
  rpn_pkg::sat_val_t         fin_res;
  logic [VW-1:0]             digit_val;

  logic                      div_start;
  logic                      div_done;
  logic [rpn_pkg::DIV_W-1:0] div_quo;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({rpn_pkg::magnitude(rd_data_r), {FW{1'b0}}}),
    .divisor  (rpn_pkg::magnitude(top_r)),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign depth_m1 = depth_r - 1'b1;
  assign depth_m2 = depth_r - 2'd2;

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    digit_val = {{(VW-rpn_pkg::DIGIT_W-FW){1'b0}}, q_item.digit, {FW{1'b0}}};
    if (op_r == rpn_pkg::CMD_SUB) begin
      sum = {rd_data_r[VW-1], rd_data_r} - {top_r[VW-1], top_r};
    end else begin
      sum = {rd_data_r[VW-1], rd_data_r} + {top_r[VW-1], top_r};
    end
    a_half = mcnt_r[1] ? ma_r[VW-1:HW] : ma_r[HW-1:0];
    b_half = mcnt_r[0] ? mb_r[VW-1:HW] : mb_r[HW-1:0];
    case (psh_r)
      2'd0:    addend = {{VW{1'b0}}, prod_r};
      2'd1:    addend = {{HW{1'b0}}, prod_r, {HW{1'b0}}};
      2'd2:    addend = {prod_r, {VW{1'b0}}};
      default: addend = '0;
    endcase
    acc_sum = acc_r + addend;
    fin_res = rpn_pkg::from_mag(mag_r, neg_r);
  end

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    sticky_nxt     = sticky_r;
    top_nxt        = top_r;
    op_nxt         = op_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    neg_nxt        = neg_r;
    mcnt_nxt       = mcnt_r;
    prod_nxt       = prod_r;
    psh_nxt        = psh_r;
    acc_nxt        = acc_r;
    mag_nxt        = mag_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_sat_nxt    = out_sat_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            rpn_pkg::CMD_DIGIT: begin
              if (depth_r == DW'(STACK_DEPTH)) begin
                // stack full: report and start over
                if (out_free) begin
                  q_pop          = 1'b1;
                  out_valid_nxt  = 1'b1;
                  out_value_nxt  = '0;
                  out_status_nxt = rpn_pkg::STAT_OVERFLOW;
                  out_sat_nxt    = sticky_r;
                  depth_nxt      = '0;
                  sticky_nxt     = 1'b0;
                end
              end else begin
                q_pop     = 1'b1;
                mem_we    = (depth_r != '0);
                top_nxt   = digit_val;
                depth_nxt = depth_r + 1'b1;
              end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
              if (depth_r < DW'(2)) begin
                if (out_free) begin
                  q_pop          = 1'b1;
                  out_valid_nxt  = 1'b1;
                  out_value_nxt  = '0;
                  out_status_nxt = rpn_pkg::STAT_UNDERFLOW;
                  out_sat_nxt    = sticky_r;
                  depth_nxt      = '0;
                  sticky_nxt     = 1'b0;
                end
              end else begin
                // fetch left operand; right operand is held in top_r
                q_pop     = 1'b1;
                mem_re    = 1'b1;
                op_nxt    = q_item.cmd;
                state_nxt = S_READ;
              end
            end
            rpn_pkg::CMD_EQUAL: begin
              if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_sat_nxt    = sticky_r;
                depth_nxt      = '0;
                sticky_nxt     = 1'b0;
                if (depth_r == '0) begin
                  out_value_nxt  = '0;
                  out_status_nxt = rpn_pkg::STAT_UNDERFLOW;
                end else begin
                  out_value_nxt  = top_r;
                  out_status_nxt = rpn_pkg::STAT_OK;
                end
              end
            end
            rpn_pkg::CMD_CLEAR: begin
              q_pop      = 1'b1;
              depth_nxt  = '0;
              sticky_nxt = 1'b0;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        case (op_r)
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
            if (sum[VW] != sum[VW-1]) begin
              top_nxt    = sum[VW] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
              sticky_nxt = 1'b1;
            end else begin
              top_nxt = sum[VW-1:0];
            end
            depth_nxt = depth_m1;
            state_nxt = S_IDLE;
          end
          rpn_pkg::CMD_MUL: begin
            ma_nxt    = rpn_pkg::magnitude(rd_data_r);
            mb_nxt    = rpn_pkg::magnitude(top_r);
            neg_nxt   = rd_data_r[VW-1] ^ top_r[VW-1];
            mcnt_nxt  = '0;
            acc_nxt   = '0;
            state_nxt = S_MUL;
          end
          rpn_pkg::CMD_DIV: begin
            if (top_r == '0) begin
              // divide by zero saturates toward the sign of the dividend
              top_nxt    = rd_data_r[VW-1] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
              sticky_nxt = 1'b1;
              depth_nxt  = depth_m1;
              state_nxt  = S_IDLE;
            end else begin
              div_start = 1'b1;
              neg_nxt   = rd_data_r[VW-1] ^ top_r[VW-1];
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_MUL: begin
        // four half-width partial products, each accumulated in the cycle after it is formed
        if (mcnt_r != 3'd4) begin
          prod_nxt = a_half * b_half;
          psh_nxt  = {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
        end
        if (mcnt_r != 3'd0) begin
          acc_nxt = acc_sum;
        end
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == 3'd4) begin
          mag_nxt   = acc_sum[PW-1:FW];
          state_nxt = S_FIN;
        end
      end

      S_DIV: begin
        if (div_done) begin
          mag_nxt   = {{(MW-rpn_pkg::DIV_W){1'b0}}, div_quo};
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        top_nxt    = fin_res.val;
        sticky_nxt = sticky_r | fin_res.sat;
        depth_nxt  = depth_m1;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    op_r         <= op_nxt;
    ma_r         <= ma_nxt;
    mb_r         <= mb_nxt;
    neg_r        <= neg_nxt;
    mcnt_r       <= mcnt_nxt;
    prod_r       <= prod_nxt;
    psh_r        <= psh_nxt;
    acc_r        <= acc_nxt;
    mag_r        <= mag_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  // stack memory holds every entry below the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth_m1[AW-1:0]] <= top_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[depth_m2[AW-1:0]];
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: tb/rpn_stack_calculator_checker.sv
// checker for the rpn calculator: predicts each result word and compares it
`timescale 1ns / 1ps
module rpn_stack_calculator_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  logic [rpn_pkg::CHAR_W-1:0]       in_character,
  input  logic                             out_pop,
  input  logic                             out_empty,
  input  logic signed [rpn_pkg::VAL_W-1:0] out_value,
  input  logic [rpn_pkg::STAT_W-1:0]       out_status,
  input  logic                             out_saturated,
  output int                               mismatches,
  output int                               outstanding
);

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef struct {
    logic [rpn_pkg::VAL_W-1:0]  value;
    logic [rpn_pkg::STAT_W-1:0] status;
    logic                       sat;
  } calc_word_t;

  calc_word_t                expected_words[$];
  logic [rpn_pkg::VAL_W-1:0] operands[rpn_pkg::DEF_STACK_DEPTH];
  int                        depth;
  logic                      sticky;
  int                        errs;

  function automatic bit decode_char(input logic [rpn_pkg::CHAR_W-1:0] ch,
                                     output rpn_pkg::cmd_t cmd);
    cmd = rpn_pkg::CMD_CLEAR;
    if (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE) begin
      cmd = rpn_pkg::CMD_DIGIT;
    end else begin
      case (ch)
        rpn_pkg::CH_PLUS:  cmd = rpn_pkg::CMD_ADD;
        rpn_pkg::CH_MINUS: cmd = rpn_pkg::CMD_SUB;
        rpn_pkg::CH_STAR:  cmd = rpn_pkg::CMD_MUL;
        rpn_pkg::CH_SLASH: cmd = rpn_pkg::CMD_DIV;
        rpn_pkg::CH_EQUAL: cmd = rpn_pkg::CMD_EQUAL;
        rpn_pkg::CH_QUIT:  cmd = rpn_pkg::CMD_CLEAR;
        default:           return 1'b0;
      endcase
    end
    return 1'b1;
  endfunction

  function automatic logic [rpn_pkg::VAL_W-1:0] abs_val(input logic [rpn_pkg::VAL_W-1:0] v);
    return v[rpn_pkg::VAL_W-1] ? ~v + 48'd1 : v;
  endfunction

  // signed value from a wide magnitude, clamped to the 48-bit range
  function automatic logic [rpn_pkg::VAL_W-1:0] clamp_mag(input logic [79:0] mag,
                                                          input bit neg);
    if (neg) begin
      if (mag > 80'h8000_0000_0000) begin
        sticky = 1'b1;
        return rpn_pkg::VAL_MIN;
      end
      return ~mag[rpn_pkg::VAL_W-1:0] + 48'd1;
    end
    if (mag > 80'h7FFF_FFFF_FFFF) begin
      sticky = 1'b1;
      return rpn_pkg::VAL_MAX;
    end
    return mag[rpn_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [rpn_pkg::VAL_W-1:0] calc_op(input rpn_pkg::cmd_t cmd,
                                                        input logic [rpn_pkg::VAL_W-1:0] l,
                                                        input logic [rpn_pkg::VAL_W-1:0] r);
    longint                      sum;
    logic [2*rpn_pkg::VAL_W-1:0] prod;
    logic [79:0]                 num;
    bit                          neg;
    neg = l[rpn_pkg::VAL_W-1] ^ r[rpn_pkg::VAL_W-1];
    case (cmd)
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
        sum = (cmd == rpn_pkg::CMD_ADD) ? $signed(l) + $signed(r) : $signed(l) - $signed(r);
        if (sum > SUM_HI) begin
          sticky = 1'b1;
          return rpn_pkg::VAL_MAX;
        end
        if (sum < SUM_LO) begin
          sticky = 1'b1;
          return rpn_pkg::VAL_MIN;
        end
        return sum[rpn_pkg::VAL_W-1:0];
      end
      rpn_pkg::CMD_MUL: begin
        // magnitude product truncated, so rounding is toward zero
        prod = abs_val(l) * abs_val(r);
        return clamp_mag(prod[2*rpn_pkg::VAL_W-1:rpn_pkg::FRAC_W], neg);
      end
      default: begin
        if (r == '0) begin
          sticky = 1'b1;
          return l[rpn_pkg::VAL_W-1] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
        end
        num = {16'd0, abs_val(l), 16'd0};
        return clamp_mag(num / {32'd0, abs_val(r)}, neg);
      end
    endcase
  endfunction

  task automatic emit_word(input logic [rpn_pkg::VAL_W-1:0] v,
                           input logic [rpn_pkg::STAT_W-1:0] st);
    calc_word_t w;
    w.value  = v;
    w.status = st;
    w.sat    = sticky;
    expected_words.push_back(w);
    depth  = 0;
    sticky = 1'b0;
  endtask

  task automatic apply_char(input logic [rpn_pkg::CHAR_W-1:0] ch);
    rpn_pkg::cmd_t              cmd;
    logic [rpn_pkg::CHAR_W-1:0] digit;
    if (!decode_char(ch, cmd)) return;
    case (cmd)
      rpn_pkg::CMD_DIGIT: begin
        digit = ch - rpn_pkg::CH_ZERO;
        if (depth >= rpn_pkg::DEF_STACK_DEPTH) begin
          emit_word('0, rpn_pkg::STAT_OVERFLOW);
        end else begin
          operands[depth] = {28'd0, digit[rpn_pkg::DIGIT_W-1:0], 16'd0};
          depth++;
        end
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (depth < 2) begin
          emit_word('0, rpn_pkg::STAT_UNDERFLOW);
        end else begin
          operands[depth-2] = calc_op(cmd, operands[depth-2], operands[depth-1]);
          depth--;
        end
      end
      rpn_pkg::CMD_EQUAL: begin
        if (depth == 0) emit_word('0, rpn_pkg::STAT_UNDERFLOW);
        else emit_word(operands[depth-1], rpn_pkg::STAT_OK);
      end
      default: begin
        depth  = 0;
        sticky = 1'b0;
      end
    endcase
  endtask

  task automatic check_word();
    calc_word_t w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word, value %h status %0d saturated %0b",
               $time, out_value, out_status, out_saturated);
      errs++;
      return;
    end
    w = expected_words.pop_front();
    if (out_value !== w.value) begin
      $display("%0t: value mismatch, expected %h, actual %h", $time, w.value, out_value);
      errs++;
    end
    if (out_status !== w.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, w.status, out_status);
      errs++;
    end
    if (out_saturated !== w.sat) begin
      $display("%0t: saturated mismatch, expected %0b, actual %0b", $time, w.sat,
               out_saturated);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      depth  = 0;
      sticky = 1'b0;
    end else begin
      if (in_push && !in_full) apply_char(in_character);
      if (out_pop && !out_empty) check_word();
    end
    mismatches  <= errs;
    outstanding <= expected_words.size();
  end

endmodule

FILE: tb/rpn_stack_calculator_core_tb.sv
// testbench top for the rpn calculator core: stimulus, idling and verdict
`timescale 1ns / 1ps
module rpn_stack_calculator_core_tb;

  // about this many command words in the random part, split over three idling phases
  localparam int TARGET_WORDS = 1300;
  // cycles with no word moving on either side before the run is called hung
  localparam int HANG_LIMIT   = 4000;
  // settle time after the last expected word, well above the divider latency
  localparam int TAIL_CYCLES  = 100;

  logic                             clk;
  logic                             rst_n        = 1'b0;
  logic                             in_push      = 1'b0;
  logic [rpn_pkg::CHAR_W-1:0]       in_character = '0;
  logic                             in_full;
  logic                             out_pop      = 1'b0;
  logic                             out_empty;
  logic signed [rpn_pkg::VAL_W-1:0] out_value;
  logic [rpn_pkg::STAT_W-1:0]       out_status;
  logic                             out_saturated;

  int mismatch_count;
  int pending_words;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int idle_cycles   = 0;

  // fixed opening: a product, an operator on an empty stack, divide by zero both signs,
  // clear then '=', ignored bytes with all bits low and high, fractional quotient
  logic [rpn_pkg::CHAR_W-1:0] opening_chars[26] = '{
    rpn_pkg::CH_ZERO + 8'd9, rpn_pkg::CH_ZERO + 8'd9, rpn_pkg::CH_STAR, rpn_pkg::CH_EQUAL,
    rpn_pkg::CH_PLUS,
    rpn_pkg::CH_ZERO + 8'd5, rpn_pkg::CH_ZERO, rpn_pkg::CH_SLASH, rpn_pkg::CH_EQUAL,
    rpn_pkg::CH_ZERO, rpn_pkg::CH_ZERO + 8'd5, rpn_pkg::CH_MINUS, rpn_pkg::CH_ZERO,
    rpn_pkg::CH_SLASH, rpn_pkg::CH_EQUAL,
    rpn_pkg::CH_ZERO + 8'd3, rpn_pkg::CH_ZERO + 8'd4, rpn_pkg::CH_PLUS, rpn_pkg::CH_QUIT,
    rpn_pkg::CH_EQUAL,
    8'h00, 8'hFF,
    rpn_pkg::CH_ZERO + 8'd7, rpn_pkg::CH_ZERO + 8'd2, rpn_pkg::CH_SLASH, rpn_pkg::CH_EQUAL
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  rpn_stack_calculator_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_character  (in_character),
    .in_full       (in_full),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_saturated (out_saturated)
  );

  rpn_stack_calculator_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_character  (in_character),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_saturated (out_saturated),
    .mismatches    (mismatch_count),
    .outstanding   (pending_words)
  );

  // receiver side: one decision per falling edge, never popping during reset
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // hang watchdog: any word moving on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == HANG_LIMIT) begin
      $display("FAIL rpn_stack_calculator_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // bytes the block acts on; everything else is dropped by it
  function automatic bit is_command(input logic [rpn_pkg::CHAR_W-1:0] ch);
    return (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE) || ch == rpn_pkg::CH_PLUS ||
           ch == rpn_pkg::CH_MINUS || ch == rpn_pkg::CH_STAR || ch == rpn_pkg::CH_SLASH ||
           ch == rpn_pkg::CH_EQUAL || ch == rpn_pkg::CH_QUIT;
  endfunction

  function automatic logic [rpn_pkg::CHAR_W-1:0] any_digit();
    return rpn_pkg::CH_ZERO + rpn_pkg::CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [rpn_pkg::CHAR_W-1:0] any_operator();
    case ($urandom_range(3))
      0:       return rpn_pkg::CH_PLUS;
      1:       return rpn_pkg::CH_MINUS;
      2:       return rpn_pkg::CH_STAR;
      default: return rpn_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [rpn_pkg::CHAR_W-1:0] junk_byte();
    logic [rpn_pkg::CHAR_W-1:0] b;
    b = rpn_pkg::CHAR_W'($urandom_range(255));
    while (is_command(b)) b = rpn_pkg::CHAR_W'($urandom_range(255));
    return b;
  endfunction

  // one word across the input side; the sender may idle first, push stays
  // high after acceptance until the next falling edge decides again
  task automatic send_word(input logic [rpn_pkg::CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push      <= 1'b1;
    in_character <= ch;
    do @(posedge clk); while (in_full);
    if (is_command(ch)) words_sent++;
  endtask

  // well-formed expression with random digits and operators; mostly short,
  // sometimes deep enough to fill most of the stack
  task automatic send_expression();
    int operands_left;
    int depth;
    operands_left = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
    depth = 0;
    while (operands_left > 0 || depth > 1) begin
      if (depth < 2 || (operands_left > 0 && $urandom_range(1))) begin
        send_word(any_digit());
        depth++;
        operands_left--;
      end else begin
        send_word(any_operator());
        depth--;
      end
      if ($urandom_range(19) == 0) send_word(junk_byte());
    end
    send_word(($urandom_range(9) == 0) ? rpn_pkg::CH_QUIT : rpn_pkg::CH_EQUAL);
  endtask

  // drives values toward the Q31.16 limits so clamping and the sticky flag fire
  task automatic send_growth();
    int steps;
    steps = $urandom_range(13, 4);
    if ($urandom_range(1)) begin
      send_word(rpn_pkg::CH_ZERO + 8'd9);
    end else begin
      send_word(rpn_pkg::CH_ZERO);
      send_word(rpn_pkg::CH_ZERO + 8'd9);
      send_word(rpn_pkg::CH_MINUS);
    end
    repeat (steps) begin
      send_word(rpn_pkg::CH_ZERO + rpn_pkg::CHAR_W'($urandom_range(9, 2)));
      send_word(($urandom_range(3) != 0) ? rpn_pkg::CH_STAR : any_operator());
    end
    // push past the rails once more, divide by zero, or add nothing
    case ($urandom_range(3))
      0: begin
        send_word(rpn_pkg::CH_ZERO + 8'd9);
        send_word(rpn_pkg::CH_PLUS);
      end
      1: begin
        send_word(rpn_pkg::CH_ZERO + 8'd9);
        send_word(rpn_pkg::CH_MINUS);
      end
      2: begin
        send_word(rpn_pkg::CH_ZERO);
        send_word(rpn_pkg::CH_SLASH);
      end
      default: ;
    endcase
    send_word(rpn_pkg::CH_EQUAL);
  endtask

  // around the stack limit: exactly full is fine, one more digit is an overflow
  task automatic send_stack_fill();
    repeat ($urandom_range(70, 60)) send_word(any_digit());
    send_word($urandom_range(1) ? rpn_pkg::CH_EQUAL : rpn_pkg::CH_QUIT);
  endtask

  // short broken runs: operators on thin stacks, stray clears, random bytes
  task automatic send_broken();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(4))
        0:       send_word(any_digit());
        1:       send_word(any_operator());
        2:       send_word(rpn_pkg::CH_EQUAL);
        3:       send_word(rpn_pkg::CH_QUIT);
        default: send_word(rpn_pkg::CHAR_W'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase one: both sides idle, sender less than receiver
    send_idle_pct = 37;
    recv_idle_pct = 48;
    foreach (opening_chars[i]) send_word(opening_chars[i]);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 48;
        recv_idle_pct = 37;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (words_sent < TARGET_WORDS * (phase + 1) / 3) begin
        pick = $urandom_range(99);
        if (pick < 60) send_expression();
        else if (pick < 75) send_growth();
        else if (pick < 78) send_stack_fill();
        else if (pick < 90) send_broken();
        else send_word(rpn_pkg::CHAR_W'($urandom_range(255)));
      end
    end

    @(negedge clk);
    in_push <= 1'b0;

    // drain: the watchdog bounds this wait
    while (pending_words != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS rpn_stack_calculator_core");
    end else begin
      $display("FAIL rpn_stack_calculator_core");
    end
    $finish;
  end

endmodule
